[rtl/core/rrts_pkg.sv]
package rrts_pkg;

    typedef enum logic [2:0] {
        TS_DEAD     = 3'd0,
        TS_READY    = 3'd1,
        TS_RUNNING  = 3'd2,
        TS_BLK_RECV = 3'd3,
        TS_BLK_SEND = 3'd4,
        TS_WAITING  = 3'd5,
        TS_ZOMBIE   = 3'd6
    } tstate_t;

    typedef enum logic [2:0] {
        OP_SCHEDULE  = 3'd0,
        OP_SIGNAL    = 3'd1,
        OP_HANDLER   = 3'd2,
        OP_NEW_THR   = 3'd3,
        OP_RM_THR    = 3'd4,
        OP_NEW_PROC  = 3'd5,
        OP_TERMINATE = 3'd6,
        OP_BLOCK     = 3'd7
    } op_t;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_INVALID  = 2'd1;
    localparam logic [1:0] STAT_INACTIVE = 2'd2;
    localparam logic [1:0] STAT_FULL     = 2'd3;

    localparam logic [1:0] HK_DEFAULT = 2'd0;
    localparam logic [1:0] HK_IGNORE  = 2'd1;
    localparam logic [1:0] HK_USER    = 2'd2;

    localparam logic [4:0] SIG_KILL = 5'd9;
    localparam logic [4:0] SIG_TERM = 5'd15;

    typedef enum logic [2:0] {
        CS_IDLE   = 3'd0,
        CS_EXEC   = 3'd1,
        CS_SWEEP  = 3'd2,
        CS_TPREP  = 3'd3,
        CS_TSCAN  = 3'd4,
        CS_TEND   = 3'd5,
        CS_OUT    = 3'd6
    } cstate_t;

    typedef struct packed {
        logic exec;
        logic sweep_step;
        logic tick_prep;
        logic scan_step;
        logic tick_end;
    } cmd_t;

    typedef struct packed {
        logic need_sweep;
        logic need_tick;
        logic sweep_last;
        logic scan_done;
    } sts_t;

endpackage

[rtl/core/rrts_ctrl.sv]
module rrts_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_fire,
    input  logic            out_fire,
    input  rrts_pkg::sts_t  sts,
    output rrts_pkg::cmd_t  cmd,
    output logic            in_ready,
    output logic            out_valid
);

    rrts_pkg::cstate_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rrts_pkg::CS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rrts_pkg::CS_IDLE: begin
                if (in_fire) state_next = rrts_pkg::CS_EXEC;
            end
            rrts_pkg::CS_EXEC: begin
                if (sts.need_sweep) state_next = rrts_pkg::CS_SWEEP;
                else if (sts.need_tick) state_next = rrts_pkg::CS_TPREP;
                else state_next = rrts_pkg::CS_OUT;
            end
            rrts_pkg::CS_SWEEP: begin
                if (sts.sweep_last) begin
                    state_next = sts.need_tick ? rrts_pkg::CS_TPREP : rrts_pkg::CS_OUT;
                end
            end
            rrts_pkg::CS_TPREP: state_next = rrts_pkg::CS_TSCAN;
            rrts_pkg::CS_TSCAN: begin
                if (sts.scan_done) state_next = rrts_pkg::CS_TEND;
            end
            rrts_pkg::CS_TEND: state_next = rrts_pkg::CS_OUT;
            rrts_pkg::CS_OUT: begin
                if (out_fire) state_next = rrts_pkg::CS_IDLE;
            end
            default: state_next = rrts_pkg::CS_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            rrts_pkg::CS_IDLE:  in_ready = 1'b1;
            rrts_pkg::CS_EXEC:  cmd.exec = 1'b1;
            rrts_pkg::CS_SWEEP: cmd.sweep_step = 1'b1;
            rrts_pkg::CS_TPREP: cmd.tick_prep = 1'b1;
            rrts_pkg::CS_TSCAN: cmd.scan_step = !sts.scan_done;
            rrts_pkg::CS_TEND:  cmd.tick_end = 1'b1;
            rrts_pkg::CS_OUT:   out_valid = 1'b1;
            default: ;
        endcase
    end

    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.exec, cmd.sweep_step, cmd.tick_prep, cmd.scan_step, cmd.tick_end}))
        else $error("multiple commands");
    a_ready_out: assert property (@(posedge aclk) disable iff (!aresetn)
        !(in_ready && out_valid)) else $error("ready while result pending");
    a_exec_after: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> cmd.exec) else $error("accept not executed");

endmodule

[rtl/core/rrts_dp.sv]
module rrts_dp #(
    parameter int THREADS   = 16,
    parameter int PROCESSES = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_fire,
    input  logic [2:0]      in_op,
    input  logic [3:0]      in_ti,
    input  logic [3:0]      in_pi,
    input  logic [4:0]      in_sig,
    input  logic [1:0]      in_hk,
    input  logic [1:0]      in_bk,
    input  logic            started,
    input  rrts_pkg::cmd_t  cmd,
    output rrts_pkg::sts_t  sts,
    output logic [1:0]      o_status,
    output logic [3:0]      o_rv,
    output logic [3:0]      o_next,
    output logic            o_sw,
    output logic [4:0]      o_dsig,
    output logic            o_reap
);

    localparam int TW = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int PW = $clog2(PROCESSES + 1);
    localparam int PIW = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
    localparam int CW = $clog2(THREADS + 1);
    localparam logic [PW-1:0] NONE_P = PW'(PROCESSES);

    rrts_pkg::tstate_t tstate_reg [THREADS];
    logic [PW-1:0]     towner_reg [THREADS];
    logic [TW-1:0]     cur_reg;
    logic [PROCESSES-1:0] pact_reg;
    logic [PW-1:0]     ppar_reg [PROCESSES];
    logic [31:0]       pend_reg [PROCESSES];
    logic [63:0]       hk_reg   [PROCESSES];

    logic [2:0] op_reg;
    logic [3:0] ti_reg, pi_reg;
    logic [4:0] sig_reg;
    logic [1:0] hk_in_reg, bk_reg;

    logic [1:0] status_reg;
    logic [3:0] rv_reg;
    logic       sw_reg, reap_reg;
    logic [4:0] dsig_reg;

    // sweep: 0 = kill (terminate also wakes parent's waiters), 1 = wake blocked
    logic [1:0]    sw_mode_reg;
    logic [PW-1:0] sw_proc_reg;
    logic [TW-1:0] idx_reg;
    logic [CW-1:0] cnt_reg;
    logic [TW-1:0] old_reg;
    logic          found_reg;

    logic [TW-1:0] cand;
    logic          pi_ok, ti_ok, is_kill;
    logic [PIW-1:0] pix;
    logic [PW-1:0]  own_cur;
    logic [1:0]     kind_pi, kind_own;
    logic [PW-1:0]  par_p;
    logic           par_wake;

    assign pi_ok = 32'(pi_reg) < PROCESSES;
    assign ti_ok = 32'(ti_reg) < THREADS;
    assign pix = PIW'(pi_reg);
    assign is_kill = (sig_reg == rrts_pkg::SIG_KILL) || (sig_reg == rrts_pkg::SIG_TERM);
    assign own_cur = towner_reg[cur_reg];
    assign kind_pi = hk_reg[pix][{sig_reg, 1'b0} +: 2];
    assign kind_own = hk_reg[PIW'(own_cur)][{sig_reg, 1'b0} +: 2];
    assign par_p = ppar_reg[pix];
    assign par_wake = (op_reg == rrts_pkg::OP_TERMINATE) && (32'(par_p) < PROCESSES);

    logic          dead_hit, free_hit;
    logic [TW-1:0] dead_idx;
    logic [PIW-1:0] free_idx;
    always_comb begin
        dead_hit = 1'b0; dead_idx = '0;
        for (int i = THREADS - 1; i >= 0; i--) begin
            if (tstate_reg[i] == rrts_pkg::TS_DEAD) begin
                dead_hit = 1'b1; dead_idx = TW'(i);
            end
        end
        free_hit = 1'b0; free_idx = '0;
        for (int i = PROCESSES - 1; i >= 0; i--) begin
            if (!pact_reg[i]) begin
                free_hit = 1'b1; free_idx = PIW'(i);
            end
        end
    end

    // scan candidate
    logic [PW-1:0]  c_own;
    logic [31:0]    c_pend;
    logic [4:0]     c_sig;
    logic           c_has;
    logic [1:0]     c_kind;
    assign cand = idx_reg;
    assign c_own = towner_reg[cand];
    assign c_pend = (32'(c_own) < PROCESSES) ? pend_reg[PIW'(c_own)] : 32'd0;
    always_comb begin
        c_sig = '0;
        for (int s = 31; s >= 1; s--) begin
            if (c_pend[s]) c_sig = 5'(s);
        end
    end
    assign c_has = c_sig != 5'd0;
    assign c_kind = hk_reg[PIW'(c_own)][{c_sig, 1'b0} +: 2];

    logic ex_valid;
    assign ex_valid = 1'b1;

    always_comb begin
        sts.need_sweep = 1'b0;
        sts.need_tick = 1'b0;
        case (op_reg)
            rrts_pkg::OP_SCHEDULE: sts.need_tick = 1'b1;
            rrts_pkg::OP_SIGNAL:
                sts.need_sweep = pi_ok && sig_reg != 5'd0 && pact_reg[pix] &&
                                 (is_kill || kind_pi != rrts_pkg::HK_IGNORE);
            rrts_pkg::OP_TERMINATE: begin
                sts.need_sweep = pi_ok;
                sts.need_tick = pi_ok;
            end
            default: ;
        endcase
        sts.sweep_last = 32'(idx_reg) == THREADS - 1;
        sts.scan_done = found_reg || 32'(cnt_reg) == THREADS;
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            op_reg <= in_op; ti_reg <= in_ti; pi_reg <= in_pi;
            sig_reg <= in_sig; hk_in_reg <= in_hk; bk_reg <= in_bk;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < THREADS; i++) begin
                tstate_reg[i] <= rrts_pkg::TS_DEAD;
                towner_reg[i] <= NONE_P;
            end
            tstate_reg[0] <= rrts_pkg::TS_RUNNING;
            towner_reg[0] <= '0;
            cur_reg <= '0;
            pact_reg <= PROCESSES'(1);
            for (int i = 0; i < PROCESSES; i++) begin
                ppar_reg[i] <= NONE_P;
                pend_reg[i] <= '0;
                hk_reg[i] <= '0;
            end
            status_reg <= '0; rv_reg <= '0; sw_reg <= 1'b0;
            dsig_reg <= '0; reap_reg <= 1'b0;
            sw_mode_reg <= '0; sw_proc_reg <= '0; idx_reg <= '0;
            cnt_reg <= '0; old_reg <= '0; found_reg <= 1'b0;
        end else begin
            if (cmd.exec && ex_valid) begin
                status_reg <= rrts_pkg::STAT_OK;
                rv_reg <= '0; sw_reg <= 1'b0; dsig_reg <= '0; reap_reg <= 1'b0;
                idx_reg <= '0;
                sw_proc_reg <= PW'(pi_reg);
                sw_mode_reg <= 2'd0;
                case (op_reg)
                    rrts_pkg::OP_SCHEDULE: ;
                    rrts_pkg::OP_SIGNAL: begin
                        if (!pi_ok || sig_reg == 5'd0) status_reg <= rrts_pkg::STAT_INVALID;
                        else if (!pact_reg[pix]) status_reg <= rrts_pkg::STAT_INACTIVE;
                        else if (!is_kill && kind_pi != rrts_pkg::HK_IGNORE) begin
                            pend_reg[pix][sig_reg] <= 1'b1;
                            sw_mode_reg <= 2'd1;
                        end
                    end
                    rrts_pkg::OP_HANDLER: begin
                        if (sig_reg == 5'd0 || hk_in_reg > 2'd2 ||
                            32'(own_cur) >= PROCESSES) begin
                            status_reg <= rrts_pkg::STAT_INVALID;
                        end else begin
                            rv_reg <= {2'b00, kind_own};
                            hk_reg[PIW'(own_cur)][{sig_reg, 1'b0} +: 2] <= hk_in_reg;
                        end
                    end
                    rrts_pkg::OP_NEW_THR: begin
                        if (!pi_ok) status_reg <= rrts_pkg::STAT_INVALID;
                        else if (!dead_hit) status_reg <= rrts_pkg::STAT_FULL;
                        else begin
                            towner_reg[dead_idx] <= PW'(pi_reg);
                            tstate_reg[dead_idx] <= rrts_pkg::TS_READY;
                            rv_reg <= 4'(dead_idx);
                        end
                    end
                    rrts_pkg::OP_RM_THR: begin
                        if (!ti_ok) status_reg <= rrts_pkg::STAT_INVALID;
                        else tstate_reg[TW'(ti_reg)] <= rrts_pkg::TS_DEAD;
                    end
                    rrts_pkg::OP_NEW_PROC: begin
                        if (!free_hit) status_reg <= rrts_pkg::STAT_FULL;
                        else begin
                            ppar_reg[free_idx] <= (started && 32'(own_cur) < PROCESSES)
                                                  ? own_cur : NONE_P;
                            pend_reg[free_idx] <= '0;
                            hk_reg[free_idx] <= '0;
                            pact_reg[free_idx] <= 1'b1;
                            rv_reg <= 4'(free_idx);
                        end
                    end
                    rrts_pkg::OP_TERMINATE: begin
                        if (!pi_ok) status_reg <= rrts_pkg::STAT_INVALID;
                        else pact_reg[pix] <= 1'b0;
                    end
                    default: begin
                        if (bk_reg > 2'd2) status_reg <= rrts_pkg::STAT_INVALID;
                        else if (bk_reg == 2'd0) tstate_reg[cur_reg] <= rrts_pkg::TS_BLK_RECV;
                        else if (bk_reg == 2'd1) tstate_reg[cur_reg] <= rrts_pkg::TS_BLK_SEND;
                        else tstate_reg[cur_reg] <= rrts_pkg::TS_WAITING;
                    end
                endcase
            end
            if (cmd.sweep_step) begin
                // one thread per cycle; terminate also wakes parent's waiters
                if (towner_reg[idx_reg] == sw_proc_reg) begin
                    if (sw_mode_reg == 2'd1) begin
                        if (tstate_reg[idx_reg] == rrts_pkg::TS_BLK_RECV ||
                            tstate_reg[idx_reg] == rrts_pkg::TS_BLK_SEND ||
                            tstate_reg[idx_reg] == rrts_pkg::TS_WAITING)
                            tstate_reg[idx_reg] <= rrts_pkg::TS_READY;
                    end else if (tstate_reg[idx_reg] != rrts_pkg::TS_DEAD) begin
                        tstate_reg[idx_reg] <= rrts_pkg::TS_ZOMBIE;
                    end
                end else if (par_wake && towner_reg[idx_reg] == par_p &&
                             tstate_reg[idx_reg] == rrts_pkg::TS_WAITING) begin
                    tstate_reg[idx_reg] <= rrts_pkg::TS_READY;
                end
                idx_reg <= sts.sweep_last ? '0 : idx_reg + 1'b1;
            end
            if (cmd.tick_prep) begin
                old_reg <= cur_reg;
                if (tstate_reg[cur_reg] == rrts_pkg::TS_RUNNING)
                    tstate_reg[cur_reg] <= rrts_pkg::TS_READY;
                idx_reg <= (32'(cur_reg) == THREADS - 1) ? '0 : cur_reg + 1'b1;
                cnt_reg <= '0;
                found_reg <= 1'b0;
            end
            if (cmd.scan_step) begin
                cnt_reg <= cnt_reg + 1'b1;
                idx_reg <= (32'(idx_reg) == THREADS - 1) ? '0 : idx_reg + 1'b1;
                if (tstate_reg[cand] == rrts_pkg::TS_READY) begin
                    if (c_has) pend_reg[PIW'(c_own)][c_sig] <= 1'b0;
                    if (c_has && c_kind != rrts_pkg::HK_USER &&
                        c_kind != rrts_pkg::HK_IGNORE &&
                        (c_sig == rrts_pkg::SIG_KILL || c_sig == rrts_pkg::SIG_TERM)) begin
                        tstate_reg[cand] <= rrts_pkg::TS_ZOMBIE;
                    end else begin
                        if (c_has && c_kind == rrts_pkg::HK_USER) dsig_reg <= c_sig;
                        found_reg <= 1'b1;
                        cur_reg <= cand;
                        sw_reg <= 1'b1;
                        tstate_reg[cand] <= rrts_pkg::TS_RUNNING;
                    end
                end
            end
            if (cmd.tick_end) begin
                if (found_reg) begin
                    if (old_reg != cur_reg && tstate_reg[old_reg] == rrts_pkg::TS_ZOMBIE) begin
                        tstate_reg[old_reg] <= rrts_pkg::TS_DEAD;
                        reap_reg <= 1'b1;
                    end
                end else if (tstate_reg[old_reg] == rrts_pkg::TS_ZOMBIE) begin
                    tstate_reg[old_reg] <= rrts_pkg::TS_DEAD;
                    reap_reg <= 1'b1;
                end else if (tstate_reg[old_reg] == rrts_pkg::TS_READY) begin
                    tstate_reg[old_reg] <= rrts_pkg::TS_RUNNING;
                end
            end
        end
    end

    assign o_status = status_reg;
    assign o_rv = rv_reg;
    assign o_next = 4'(cur_reg);
    assign o_sw = sw_reg;
    assign o_dsig = dsig_reg;
    assign o_reap = reap_reg;

    a_cur_state: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.tick_end && found_reg |=> tstate_reg[cur_reg] == rrts_pkg::TS_RUNNING)
        else $error("picked thread not running");
    a_sw_dsig: assert property (@(posedge aclk) disable iff (!aresetn)
        (dsig_reg != 5'd0) |-> sw_reg) else $error("signal delivered without switch");
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(cnt_reg) <= THREADS) else $error("scan overrun");

endmodule

[rtl/core/round_robin_thread_scheduler_top.sv]
// Flow: an accepted word is executed and its result registered and offered; signal and terminate
// add a sweep over the THREADS slots, and a schedule tick (also on terminate) adds a scan.
// Throughput: one word at a time; a new word is accepted only after the last result is taken,
// and the sweep and scan each cover one slot per cycle.
// Reset: aresetn synchronous active low; thread 0 running in process 0, all else cleared.
module round_robin_thread_scheduler_top #(
    parameter int THREADS   = 16,
    parameter int PROCESSES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // operation[2:0], thread_index[6:3], process_index[10:7], signal_number[15:11],
    // handler_kind[17:16], block_kind[19:18]
    input  logic [23:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[1:0], result_value[5:2], next_thread[9:6], switched[10],
    // delivered_signal[15:11], reaped_thread_valid[16]
    output logic [23:0] m_tdata
);

    logic started_reg;
    logic in_fire, out_fire;
    rrts_pkg::cmd_t cmd;
    rrts_pkg::sts_t sts;
    logic [1:0] st;
    logic [3:0] rv, nt;
    logic sw, rp;
    logic [4:0] ds;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg <= 1'b0;
        end else if (cfg_we) begin
            started_reg <= cfg_wdata;
        end
    end

    assign in_fire = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    rrts_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire), .out_fire(out_fire),
        .sts(sts), .cmd(cmd), .in_ready(s_tready), .out_valid(m_tvalid)
    );

    rrts_dp #(.THREADS(THREADS), .PROCESSES(PROCESSES)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire),
        .in_op(s_tdata[2:0]), .in_ti(s_tdata[6:3]), .in_pi(s_tdata[10:7]),
        .in_sig(s_tdata[15:11]), .in_hk(s_tdata[17:16]), .in_bk(s_tdata[19:18]),
        .started(started_reg), .cmd(cmd), .sts(sts),
        .o_status(st), .o_rv(rv), .o_next(nt), .o_sw(sw), .o_dsig(ds), .o_reap(rp)
    );

    assign m_tdata = {7'd0, rp, ds, sw, nt, rv, st};

endmodule
